[design/word_repack_32_to_27_defines.svh]
// Assertion macros for the top-level file, which checks its own logic.
`ifndef WORD_REPACK_32_TO_27_DEFINES_SVH
`define WORD_REPACK_32_TO_27_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WRP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/wrp_pkg.sv]
package wrp_pkg;

  localparam int IN_W = 32;
  localparam int TBC_W = 6;

  typedef struct packed {
    logic pending;
    logic last_slice;
  } wrp_ctl_t;

  function automatic logic [TBC_W-1:0] top_bit_count(input logic [IN_W-1:0] v);
    logic [TBC_W-1:0] n;
    n = '0;
    for (int i = 0; i < IN_W; i++) begin
      if (v[i]) begin
        n = TBC_W'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

[design/wrp_merge.sv]
module wrp_merge #(
  parameter int OUT_WIDTH = 27
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [wrp_pkg::IN_W-1:0] in_word_i,
  input  logic                    in_last_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    take_i,
  output wrp_pkg::wrp_ctl_t       ctl_o,
  output logic [OUT_WIDTH-1:0]    slice_o
);
  import wrp_pkg::*;

  localparam int BUF_W = OUT_WIDTH + IN_W - 1;
  localparam int CNT_W = $clog2(BUF_W + 1);
  localparam logic [CNT_W-1:0] OW = CNT_W'(OUT_WIDTH);

  logic [BUF_W-1:0] buf_q, buf_d, buf_s, buf_mask;
  logic [CNT_W-1:0] rem_q, rem_d, rem_s, total;
  logic             last_q, last_d;
  logic             pending, final_slice, accept;

  assign pending     = last_q ? (rem_q != '0) : (rem_q >= OW);
  assign final_slice = last_q ? (rem_q <= OW) : ((rem_q - OW) < OW);
  assign in_ready_o  = !pending || (take_i && final_slice);
  assign accept      = in_valid_i && in_ready_o;

  assign ctl_o.pending     = pending;
  assign ctl_o.last_slice  = last_q && final_slice;
  assign slice_o           = buf_q[OUT_WIDTH-1:0];

  always_comb begin
    buf_s = take_i ? (buf_q >> OUT_WIDTH) : buf_q;
    rem_s = rem_q;
    if (take_i) begin
      if (last_q) begin
        rem_s = (rem_q > OW) ? (rem_q - OW) : '0;
      end else begin
        rem_s = rem_q - OW;
      end
    end
    buf_mask = ~({BUF_W{1'b1}} << rem_s);
    total    = rem_s + CNT_W'(top_bit_count(in_word_i));
    buf_d    = buf_s;
    rem_d    = rem_s;
    last_d   = last_q;
    if (accept) begin
      buf_d  = (buf_s & buf_mask) | (BUF_W'(in_word_i) << rem_s);
      last_d = in_last_i;
      if (in_last_i) begin
        rem_d = (total == '0) ? CNT_W'(1) : total;
      end else begin
        rem_d = rem_s + CNT_W'(IN_W);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      last_q <= 1'b0;
    end else begin
      rem_q  <= rem_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

endmodule

[design/wrp_out.sv]
module wrp_out #(
  parameter int OUT_WIDTH = 27,
  parameter int DATA_W    = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  wrp_pkg::wrp_ctl_t    ctl_i,
  input  logic [OUT_WIDTH-1:0] slice_i,
  output logic                 take_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic [DATA_W-1:0]    data_o,
  output logic                 last_o
);
  import wrp_pkg::*;

  logic                 valid_q, valid_d;
  logic [OUT_WIDTH-1:0] word_q;
  logic                 last_q;

  assign take_o  = ctl_i.pending && (!valid_q || ready_i);
  assign valid_d = take_o || (valid_q && !ready_i);
  assign valid_o = valid_q;
  assign data_o  = DATA_W'(word_q);
  assign last_o  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      word_q <= slice_i;
      last_q <= ctl_i.last_slice;
    end
  end

endmodule

[design/word_repack_32_to_27.sv]
// An accepted input item is registered in the merge buffer, then its slices in the output register.
// One result item per cycle while the receiver stays ready; an input item yields one to
// ceil((OUT_WIDTH + 31) / OUT_WIDTH) result items, sent through the single output register.
// Input items are taken back to back whenever the current item needs at most one more slot and the output takes it.
// Reset clears the held-over bit count, the run state and the output valid flag.
`include "word_repack_32_to_27_defines.svh"

module word_repack_32_to_27 #(
  parameter int OUT_WIDTH = 27
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [31:0]       s_axis_tdata_i,   // in_word
  input  logic              s_axis_tlast_i,   // is_last
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [((OUT_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata_o,   // out_word, then zero fill
  output logic              m_axis_tlast_o    // out_last
);
  import wrp_pkg::*;

  localparam int DATA_W = ((OUT_WIDTH + 7) / 8) * 8;

  wrp_ctl_t             ctl;
  logic [OUT_WIDTH-1:0] slice;
  logic                 take;

  wrp_merge #(
    .OUT_WIDTH(OUT_WIDTH)
  ) u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_word_i (s_axis_tdata_i),
    .in_last_i (s_axis_tlast_i),
    .in_valid_i(s_axis_tvalid_i),
    .in_ready_o(s_axis_tready_o),
    .take_i    (take),
    .ctl_o     (ctl),
    .slice_o   (slice)
  );

  wrp_out #(
    .OUT_WIDTH(OUT_WIDTH),
    .DATA_W   (DATA_W)
  ) u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .slice_i(slice),
    .take_o (take),
    .valid_o(m_axis_tvalid_o),
    .ready_i(m_axis_tready_i),
    .data_o (m_axis_tdata_o),
    .last_o (m_axis_tlast_o)
  );

  `WRP_ASSERT_NEXT(a_last_slice_flagged, clk_i, rst_ni, take && ctl.last_slice,
                   m_axis_tvalid_o && m_axis_tlast_o, "final slice lost its last flag")
  `WRP_ASSERT_NEXT(a_mid_slice_unflagged, clk_i, rst_ni, take && !ctl.last_slice,
                   m_axis_tvalid_o && !m_axis_tlast_o, "inner slice carries a last flag")
  `WRP_ASSERT_SAME(a_no_overwrite, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i,
                   !take, "slice taken into a stalled output register")

endmodule

[bench/repack_checker.sv]
module repack_checker #(
  parameter int LIMB_W = 27,
  parameter int DATA_W = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  input  logic              s_axis_tready_i,
  input  logic [31:0]       s_axis_tdata_i,   // in_word
  input  logic              s_axis_tlast_i,   // is_last
  input  logic              m_axis_tvalid_i,
  input  logic              m_axis_tready_i,
  input  logic [DATA_W-1:0] m_axis_tdata_i,   // out_word, then zero fill
  input  logic              m_axis_tlast_i,   // out_last
  output int                fail_count_o,
  output int                pending_o
);

  typedef struct packed {
    logic [LIMB_W-1:0] word;
    logic              last;
  } out_limb_t;

  out_limb_t         expected_limbs[$];
  logic [LIMB_W-2:0] held_bits;
  int                held_count;

  function automatic int significant_bits(input logic [31:0] value);
    int n;
    n = 0;
    for (int i = 0; i < 32; i++) begin
      if (value[i]) begin
        n = i + 1;
      end
    end
    return n;
  endfunction

  // Appends the output limbs that one input limb completes and updates the held bits.
  task automatic repack_limb(input logic [31:0] word, input logic top);
    logic [63:0] acc;
    int          total;
    out_limb_t   limb;
    acc = (64'(held_bits) & ((64'd1 << held_count) - 64'd1)) | (64'(word) << held_count);
    if (!top) begin
      total = held_count + 32;
      while (total >= LIMB_W) begin
        limb.word = acc[LIMB_W-1:0];
        limb.last = 1'b0;
        expected_limbs.push_back(limb);
        acc = acc >> LIMB_W;
        total = total - LIMB_W;
      end
      held_bits = acc[LIMB_W-2:0];
      held_count = total;
    end else begin
      total = held_count + significant_bits(word);
      if (total == 0) begin
        limb.word = '0;
        limb.last = 1'b1;
        expected_limbs.push_back(limb);
      end
      while (total > 0) begin
        limb.word = acc[LIMB_W-1:0];
        acc = acc >> LIMB_W;
        total = (total > LIMB_W) ? total - LIMB_W : 0;
        limb.last = (total == 0);
        expected_limbs.push_back(limb);
      end
      held_bits = '0;
      held_count = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_limb_t want;
    if (!rst_ni) begin
      expected_limbs.delete();
      held_bits = '0;
      held_count = 0;
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        repack_limb(s_axis_tdata_i, s_axis_tlast_i);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_limbs.size() == 0) begin
          $display("%0t: unexpected output item, expected none, actual data %h last %b",
                   $time, m_axis_tdata_i, m_axis_tlast_i);
          fail_count_o++;
        end else begin
          want = expected_limbs.pop_front();
          if (m_axis_tdata_i !== DATA_W'(want.word)) begin
            $display("%0t: out_word mismatch, expected %h, actual %h",
                     $time, DATA_W'(want.word), m_axis_tdata_i);
            fail_count_o++;
          end
          if (m_axis_tlast_i !== want.last) begin
            $display("%0t: out_last mismatch, expected %b, actual %b",
                     $time, want.last, m_axis_tlast_i);
            fail_count_o++;
          end
        end
      end
      pending_o = expected_limbs.size();
    end
  end

endmodule

[bench/tb.sv]
module tb;

  localparam int LIMB_W = 27;
  localparam int DATA_W = 32;
  localparam int RANDOM_ITEMS = 480;
  localparam int IDLE_LIMIT = 4000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [31:0]       s_axis_tdata = '0;
  logic              s_axis_tlast = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DATA_W-1:0] m_axis_tdata;
  logic              m_axis_tlast;
  int                fail_count;
  int                pending;
  int                items_sent = 0;
  int                burst_left = 0;
  int                idle_cycles = 0;
  int                stall_mode = 0;
  int                stall_left = 0;
  int                stall_run = 0;

  always #6 clk_i = ~clk_i;

  word_repack_32_to_27 #(.OUT_WIDTH(LIMB_W)) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  repack_checker #(.LIMB_W(LIMB_W), .DATA_W(DATA_W)) i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tlast_i  (m_axis_tlast),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // The receiver switches between always ready, coin flips, sparse ready and alternating runs of stalls and ready.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: begin
        m_axis_tready <= 1'b1;
      end
      1: begin
        m_axis_tready <= $urandom_range(0, 1);
      end
      2: begin
        m_axis_tready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        if (stall_run == 0) begin
          stall_run <= $urandom_range(1, 12);
          m_axis_tready <= ~m_axis_tready;
        end else begin
          stall_run <= stall_run - 1;
        end
      end
    endcase
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("word_repack_32_to_27 verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(input logic [31:0] word, input logic top);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= word;
    s_axis_tlast <= top;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, 7);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] body_limb();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] top_limb();
    case ($urandom_range(0, 9))
      0, 1: return 32'h0;
      2: return 32'h1 << $urandom_range(0, 31);
      3: return 32'hFFFF_FFFF;
      4, 5: return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_number();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      len = $urandom_range(1, 4);
    end else if (pick < 88) begin
      len = $urandom_range(5, 12);
    end else begin
      len = $urandom_range(13, 32);
    end
    for (int i = 0; i < len - 1; i++) begin
      send_item(body_limb(), 1'b0);
    end
    send_item(top_limb(), 1'b1);
  endtask

  initial begin
    int numbers;
    int target;
    numbers = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero number with nothing held, then single limbs around the output width.
    send_item(32'h0000_0000, 1'b1);
    send_item(32'hFFFF_FFFF, 1'b1);
    send_item(32'h0000_0001, 1'b1);
    send_item(32'h8000_0000, 1'b1);
    send_item(32'h07FF_FFFF, 1'b1);
    send_item(32'h0800_0000, 1'b1);
    // A zero top limb trims the number to the held bits, zero or not.
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'h0000_0000, 1'b1);
    send_item(32'h0000_0000, 1'b0);
    send_item(32'h0000_0000, 1'b1);
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b1);
    send_item(32'hAAAA_AAAA, 1'b0);
    send_item(32'h5555_5555, 1'b0);
    send_item(32'h1234_5678, 1'b1);
    send_item(32'hDEAD_BEEF, 1'b0);
    send_item(32'h0000_0001, 1'b1);
    drain_results();

    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      send_number();
      numbers++;
      if (numbers % 10 == 0) begin
        drain_results();
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("word_repack_32_to_27 verification clean");
    end else begin
      $display("word_repack_32_to_27 verification failed");
    end
    $finish;
  end

endmodule
